// File: rtl/core/ppg_pkg.sv
// ----------------------------------------------------------------------------
// ppg_pkg
// Shared constants and the quarter-wave sine builder for the plasma pixel
// generator.
// ----------------------------------------------------------------------------
package ppg_pkg;

  localparam int TABLE_SIZE    = 360;
  localparam int QUARTER       = 90;
  localparam int FRAC_BITS_DEF = 14;

  // stream payload widths
  localparam int COL_W  = 8;
  localparam int ROW_W  = 7;
  localparam int TIME_W = 32;
  localparam int IN_W   = 48;
  localparam int CH_W   = 8;
  localparam int OUT_W  = 24;

  // time / 10 and time / 15 by reciprocal, exact for every 32-bit time
  localparam int          RECIP_SHIFT = 35;
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam logic [31:0] RECIP_15    = 32'h8888_8889;

  // angle reduction modulo TABLE_SIZE, exact for operands below 2**NUM_W
  localparam int               NUM_W           = 29;
  localparam int               PROD_W          = 2 * NUM_W;
  localparam int               RECIP_360_SHIFT = 37;
  localparam logic [NUM_W-1:0] RECIP_360       = 29'd381774871;
  localparam int               QUOT_W          = PROD_W - RECIP_360_SHIFT;
  localparam int               ANGLE_W         = 9;
  localparam int               IDX_W           = 7;

  localparam int LEVEL_GAIN = 42;
  localparam int LEVEL_MAX  = 255;
  localparam int LEVEL_W    = 9;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // sine of a whole degree in 0..90 as unsigned fixed point with frac fraction
  // bits, from a Q30 taylor series; evaluated at elaboration only
  function automatic logic [31:0] quarter_sine(input int unsigned deg,
                                               input int unsigned frac);
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    longint       acc;
    longint       r;
    longint       one;
    int unsigned  n;
    x    = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    one  = 64'sd1 <<< frac;
    for (n = 1; n <= 19; n += 2) begin
      term = ((term * x2) >> 30) / 64'((n + 1) * (n + 2));
      if ((((n + 1) >> 1) & 1) != 0) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = (acc + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
    if (r > one) begin
      r = one;
    end
    return 32'(r);
  endfunction

endpackage

// File: rtl/core/ppg_mod360.sv
// ----------------------------------------------------------------------------
// ppg_mod360
// Two-stage reduction of a degree count modulo the sine table size, using a
// reciprocal multiply and one multiply-back subtract.
// ----------------------------------------------------------------------------
module ppg_mod360 (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ppg_pkg::NUM_W-1:0]   num,
  output logic [ppg_pkg::ANGLE_W-1:0] angle
);
  import ppg_pkg::*;

  logic [NUM_W-1:0]  num_d;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [NUM_W-1:0]  back;
  logic [NUM_W-1:0]  diff;

  always_ff @(posedge clk) begin
    if (en) begin
      num_d <= num;
      prod  <= PROD_W'(num) * PROD_W'(RECIP_360);
    end
  end

  always_comb begin
    quot = prod[RECIP_360_SHIFT +: QUOT_W];
    back = NUM_W'(quot) * NUM_W'(TABLE_SIZE);
    diff = num_d - back;
  end

  // remainder is below the table size, so the low bits hold it
  always_ff @(posedge clk) begin
    if (en) begin
      angle <= diff[ANGLE_W-1:0];
    end
  end

endmodule

// File: rtl/core/plasma_pixel_generator.sv
// ----------------------------------------------------------------------------
// plasma_pixel_generator
// Sine-table plasma pixel: three time-shifted angles, summed sines, color map.
// ----------------------------------------------------------------------------
// One pixel per clock cycle while the output is not stalled. The
// seven-stage pipeline (time reciprocal multiply, angle sums, modulo multiply,
// modulo subtract, quarter-wave sine lookup, sine sum, level and color) moves
// as a whole: it advances whenever the output register is empty or being
// taken, so a stalled output holds every stage in place. The sine table is a
// 91-entry quarter wave built at elaboration; sign and mirror give the rest.
module plasma_pixel_generator #(
  parameter int FRAC_BITS = ppg_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [ppg_pkg::IN_W-1:0]  s_axis_tdata,  // column, row, time_ms, pad
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [ppg_pkg::OUT_W-1:0] m_axis_tdata   // red, green, blue
);
  import ppg_pkg::*;

  localparam int QW     = FRAC_BITS + 1;
  localparam int SW     = FRAC_BITS + 2;
  localparam int SUM_W  = FRAC_BITS + 3;
  localparam int LVL_W  = FRAC_BITS + 9;
  localparam int NSTAGE = 7;

  logic              en;
  logic [NSTAGE-1:0] vld;

  assign en            = !vld[NSTAGE-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], s_axis_tvalid};
    end
  end

  // stage 1: reciprocal products for time / 10 and time / 15
  logic [COL_W-1:0] col1;
  logic [ROW_W-1:0] row1;
  logic [63:0]      p10;
  logic [63:0]      p15;

  always_ff @(posedge clk) begin
    if (en) begin
      col1 <= s_axis_tdata[COL_W-1:0];
      row1 <= s_axis_tdata[COL_W +: ROW_W];
      p10  <= 64'(s_axis_tdata[COL_W+ROW_W +: TIME_W]) * 64'(RECIP_10);
      p15  <= 64'(s_axis_tdata[COL_W+ROW_W +: TIME_W]) * 64'(RECIP_15);
    end
  end

  // stage 2: degree counts before reduction; time / 20 is half of time / 10
  logic [NUM_W-1:0] num [3];

  always_ff @(posedge clk) begin
    if (en) begin
      num[0] <= NUM_W'(p10[RECIP_SHIFT +: NUM_W]) + NUM_W'(col1);
      num[1] <= NUM_W'(p15[RECIP_SHIFT +: NUM_W]) + NUM_W'(row1);
      num[2] <= NUM_W'(p10[RECIP_SHIFT+1 +: NUM_W-1]) + NUM_W'(col1) + NUM_W'(row1);
    end
  end

  // stages 3 and 4: modulo the table size
  logic [ANGLE_W-1:0] ang [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ppg_mod360 u_mod (
      .clk   (clk),
      .en    (en),
      .num   (num[i]),
      .angle (ang[i])
    );
  end

  // quarter-wave table, constant
  logic [QW-1:0] qsin_rom [0:QUARTER];

  for (genvar d = 0; d <= QUARTER; d++) begin : g_qsin
    localparam logic [QW-1:0] QV = QW'(quarter_sine(d, FRAC_BITS));
    assign qsin_rom[d] = QV;
  end

  // stage 5: fold each angle onto the quarter wave and look up
  logic [IDX_W-1:0]    idx [3];
  logic                neg [3];
  logic signed [SW-1:0] mag [3];
  logic signed [SW-1:0] sine [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ang[i] <= ANGLE_W'(QUARTER)) begin
        idx[i] = IDX_W'(ang[i]);
        neg[i] = 1'b0;
      end else if (ang[i] < ANGLE_W'(2 * QUARTER)) begin
        idx[i] = IDX_W'(ANGLE_W'(2 * QUARTER) - ang[i]);
        neg[i] = 1'b0;
      end else if (ang[i] <= ANGLE_W'(3 * QUARTER)) begin
        idx[i] = IDX_W'(ang[i] - ANGLE_W'(2 * QUARTER));
        neg[i] = 1'b1;
      end else begin
        idx[i] = IDX_W'(ANGLE_W'(TABLE_SIZE) - ang[i]);
        neg[i] = 1'b1;
      end
      mag[i] = signed'(SW'(qsin_rom[idx[i]]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sine[i] <= neg[i] ? -mag[i] : mag[i];
      end
    end
  end

  // stage 6: sum plus 3.0, never negative since each sine is at least -1.0
  logic signed [SW+1:0] sum_c;
  logic [SUM_W-1:0]     sum_q;

  always_comb begin
    sum_c = (SW+2)'(sine[0]) + (SW+2)'(sine[1]) + (SW+2)'(sine[2])
          + (SW+2)'(3 <<< FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_q <= SUM_W'(unsigned'(sum_c));
    end
  end

  // stage 7: scale, truncate, saturate, color map
  logic [LVL_W-1:0]   scaled;
  logic [LEVEL_W-1:0] lvl_raw;
  logic [CH_W-1:0]    level;
  logic [OUT_W-1:0]   out_q;

  always_comb begin
    scaled  = LVL_W'(sum_q) * LVL_W'(LEVEL_GAIN);
    lvl_raw = scaled[FRAC_BITS +: LEVEL_W];
    if (lvl_raw > LEVEL_W'(LEVEL_MAX)) begin
      level = CH_W'(LEVEL_MAX);
    end else begin
      level = lvl_raw[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_q <= {CH_W'(LEVEL_MAX) - level, {1'b0, level[CH_W-1:1]}, level};
    end
  end

  assign m_axis_tdata = out_q;

`ifndef SYNTH
  a_blue_mirrors_red: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (9'(m_axis_tdata[7:0]) + 9'(m_axis_tdata[23:16])) == 9'd255)
    else $error("blue is not 255 minus red");

  a_green_half_red: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:8] == {1'b0, m_axis_tdata[7:1]})
    else $error("green is not half of red");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:0] <= 8'd252)
    else $error("level beyond the largest reachable value");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while the output could move");
`endif

endmodule

// File: bench/plasma_color_checker.sv
// ----------------------------------------------------------------------------
// plasma_color_checker
// Watches the pixel request and color result streams of the plasma pixel
// generator. It predicts each color from its own sine table and compares the
// results in order, field by field.
// ----------------------------------------------------------------------------
module plasma_color_checker #(
  parameter int FRAC = ppg_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic                      req_ready,
  input  logic [ppg_pkg::IN_W-1:0]  req_data,   // column, row, time_ms, pad
  input  logic                      res_valid,
  input  logic                      res_ready,
  input  logic [ppg_pkg::OUT_W-1:0] res_data,   // red, green, blue
  output int                        fail_count,
  output int                        pending_count,
  output int                        checked_count,
  output int                        level_lo,
  output int                        level_hi
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEGREES  = ppg_pkg::TABLE_SIZE;
  localparam int RIGHT    = ppg_pkg::QUARTER;
  localparam int ROW_LSB  = ppg_pkg::COL_W;
  localparam int TIME_LSB = ppg_pkg::COL_W + ppg_pkg::ROW_W;
  localparam longint unsigned PI_Q30_TB = 64'd3373259426;
  localparam int GAIN      = 42;
  localparam int LEVEL_TOP = 255;

  // red sits in the low byte, as on the bus
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  int     sine_deg [DEGREES];
  color_t pending_colors [$];

  // sine of 0..90 degrees in fixed point, taylor series evaluated in q30
  function automatic int quarter_wave(input int unsigned deg);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint          acc;
    longint          q;
    ang    = (64'(deg) * PI_Q30_TB + 64'd90) / 64'd180;
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = longint'(ang);
    for (int unsigned k = 1; k <= 19; k += 2) begin
      term = ((term * ang_sq) >> 30) / 64'((k + 1) * (k + 2));
      // x^3, x^7, x^11 ... are subtracted
      if (((k + 1) / 2) % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q = (acc + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    if (q > (64'sd1 <<< FRAC)) begin
      q = 64'sd1 <<< FRAC;
    end
    return int'(q);
  endfunction

  function automatic color_t plasma_color(input logic [7:0]  col,
                                          input logic [6:0]  row,
                                          input logic [31:0] t_ms);
    longint unsigned a1;
    longint unsigned a2;
    longint unsigned a3;
    longint          sum;
    longint          level;
    color_t          c;
    a1    = (64'(col) + 64'(t_ms) / 10) % DEGREES;
    a2    = (64'(row) + 64'(t_ms) / 15) % DEGREES;
    a3    = (64'(col) + 64'(row) + 64'(t_ms) / 20) % DEGREES;
    sum   = longint'(sine_deg[a1]) + longint'(sine_deg[a2]) + longint'(sine_deg[a3])
          + (longint'(3) <<< FRAC);
    if (sum < 0) begin
      sum = 0;
    end
    level = (sum * GAIN) >>> FRAC;
    if (level > LEVEL_TOP) begin
      level = LEVEL_TOP;
    end
    c.red   = 8'(level);
    c.green = 8'(level / 2);
    c.blue  = 8'(LEVEL_TOP - level);
    return c;
  endfunction

  initial begin : build_sine
    for (int d = 0; d < DEGREES; d++) begin
      if (d <= RIGHT) begin
        sine_deg[d] = quarter_wave(d);
      end else if (d < 2 * RIGHT) begin
        sine_deg[d] = quarter_wave(2 * RIGHT - d);
      end else if (d <= 3 * RIGHT) begin
        sine_deg[d] = -quarter_wave(d - 2 * RIGHT);
      end else begin
        sine_deg[d] = -quarter_wave(DEGREES - d);
      end
    end
  end

  always @(posedge clk) begin : compare
    color_t want;
    color_t got;
    int     errs;
    if (rst) begin
      fail_count    <= 0;
      pending_count <= 0;
      checked_count <= 0;
      level_lo      <= LEVEL_TOP;
      level_hi      <= 0;
    end else begin
      errs = 0;
      // results first, so a stray result never meets a request of this edge
      if (res_valid && res_ready) begin
        got = res_data;
        if (pending_colors.size() == 0) begin
          $error("color result %h with no request waiting", got);
          errs++;
        end else begin
          want = pending_colors.pop_front();
          if (got.red != want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            errs++;
          end
          if (got.green != want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            errs++;
          end
          if (got.blue != want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            errs++;
          end
          checked_count <= checked_count + 1;
          if (int'(want.red) < level_lo) begin
            level_lo <= int'(want.red);
          end
          if (int'(want.red) > level_hi) begin
            level_hi <= int'(want.red);
          end
        end
      end
      if (req_valid && req_ready) begin
        pending_colors.push_back(plasma_color(req_data[ROW_LSB-1:0],
                                              req_data[TIME_LSB-1:ROW_LSB],
                                              req_data[TIME_LSB+31:TIME_LSB]));
      end
      pending_count <= pending_colors.size();
      fail_count    <= fail_count + errs;
    end
  end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives pixel requests into the plasma pixel generator: a directed set of
// corner pixels, then raster runs and scattered pixels with random stalls on
// both streams. The checker beside the block predicts and compares colors.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC         = ppg_pkg::FRAC_BITS_DEF;
  localparam int FRAME_W      = 160;
  localparam int FRAME_H      = 120;
  localparam int PIXEL_COUNT  = 1550;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 6;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [ppg_pkg::IN_W-1:0]  s_axis_tdata;   // column, row, time_ms, pad
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [ppg_pkg::OUT_W-1:0] m_axis_tdata;   // red, green, blue

  int fail_count;
  int pending_count;
  int checked_count;
  int level_lo;
  int level_hi;

  int sent;
  int directed_count;
  int stall_cycles;
  bit steady;
  bit hold_req;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  plasma_pixel_generator #(
    .FRAC_BITS(FRAC)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  plasma_color_checker #(
    .FRAC(FRAC)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (s_axis_tvalid),
    .req_ready    (s_axis_tready),
    .req_data     (s_axis_tdata),
    .res_valid    (m_axis_tvalid),
    .res_ready    (m_axis_tready),
    .res_data     (m_axis_tdata),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .checked_count(checked_count),
    .level_lo     (level_lo),
    .level_hi     (level_hi)
  );

  task automatic send_pixel(input logic [7:0] col, input logic [6:0] row,
                            input logic [31:0] t_ms);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      gap++;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, t_ms, row, col};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  // wait until every request in flight has come back as a color
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int          col;
    int          row;
    int          run;
    bit          hold_issued;
    bit          drain_issued;
    logic [31:0] t_ms;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    hold_issued   = 1'b0;
    drain_issued  = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // corners of the fields, divider boundaries, peaks and troughs
    send_pixel(8'd0,   7'd0,   32'd0);
    send_pixel(8'd159, 7'd119, 32'd0);
    send_pixel(8'd255, 7'd127, 32'd0);
    send_pixel(8'd0,   7'd0,   32'hFFFF_FFFF);
    send_pixel(8'd255, 7'd127, 32'hFFFF_FFFF);
    send_pixel(8'd90,  7'd0,   32'd0);
    send_pixel(8'd200, 7'd70,  32'd0);
    send_pixel(8'd45,  7'd45,  32'd0);
    send_pixel(8'd0,   7'd0,   32'd9);
    send_pixel(8'd0,   7'd0,   32'd10);
    send_pixel(8'd0,   7'd0,   32'd14);
    send_pixel(8'd0,   7'd0,   32'd15);
    send_pixel(8'd0,   7'd0,   32'd19);
    send_pixel(8'd0,   7'd0,   32'd20);
    send_pixel(8'd0,   7'd0,   32'd3599);
    send_pixel(8'd0,   7'd0,   32'd3600);
    send_pixel(8'd0,   7'd0,   32'd900);
    // outside the frame: no clipping
    send_pixel(8'd160, 7'd120, 32'd1000);
    send_pixel(8'd255, 7'd0,   32'd5400);
    send_pixel(8'hAA,  7'h55,  32'hAAAA_AAAA);
    send_pixel(8'h55,  7'h2A,  32'h5555_5555);
    send_pixel(8'd1,   7'd1,   32'h8000_0000);
    directed_count = sent;

    while (sent < PIXEL_COUNT) begin
      steady = (sent >= 1000 && sent < 1250);
      if (!hold_issued && sent >= 400) begin
        hold_req    = 1'b1;
        hold_issued = 1'b1;
      end
      if (!drain_issued && sent >= 800) begin
        drain_issued = 1'b1;
        drain_pipeline();
      end
      if ($urandom_range(3) == 0) begin
        send_pixel(8'($urandom_range(255)), 7'($urandom_range(127)), $urandom);
      end else begin
        // a raster run at a fixed frame time, wrapping onto the next line
        col  = $urandom_range(FRAME_W - 1);
        row  = $urandom_range(FRAME_H - 1);
        t_ms = $urandom_range(1) ? $urandom : $urandom_range(600000);
        run  = $urandom_range(48, 8);
        repeat (run) begin
          send_pixel(8'(col), 7'(row), t_ms);
          col++;
          if (col == FRAME_W) begin
            col = 0;
            row = (row == FRAME_H - 1) ? 0 : row + 1;
          end
        end
      end
    end
    steady = 1'b0;

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d pixel requests (%0d directed, rest raster runs and scattered pixels),",
             sent, directed_count);
    $display("%0d colors checked, levels %0d..%0d, one long result stall, one full drain",
             checked_count, level_lo, level_hi);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : result_side
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold-off so the pipeline fills and stalls the request side
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
